// ----- rtl/cbe_pkg.sv -----
`timescale 1ns / 1ps

package cbe_pkg;

  // parameter samples per unit interval, kept a power of two so that the
  // quantization and the final normalization are plain shifts
  localparam int STEPS_LOG2 = 8;
  localparam int STEPS      = 1 << STEPS_LOG2;

  localparam int POS_W      = 18;
  localparam int FRAC_POS   = 16;
  localparam int COORD_W    = 16;
  localparam int FRAC_COORD = 14;
  localparam int IDX_W      = 9;

  // sample index and u = STEPS - k, both reach STEPS
  localparam int K_W       = STEPS_LOG2 + 1;
  // bernstein weights scaled by STEPS^3, largest is k^3 = STEPS^3
  localparam int W_W       = 3 * STEPS_LOG2 + 1;
  localparam int P_W       = W_W + 1 + COORD_W;
  localparam int SUM_W     = P_W + 2;
  localparam int RND_SHIFT = 3 * STEPS_LOG2;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    REG_C1X = 2'd0,
    REG_C1Y = 2'd1,
    REG_C2X = 2'd2,
    REG_C2Y = 2'd3
  } cbe_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] c1_x;
    logic signed [COORD_W-1:0] c1_y;
    logic signed [COORD_W-1:0] c2_x;
    logic signed [COORD_W-1:0] c2_y;
  } cbe_ctrl_t;

  typedef struct packed {
    logic           valid;
    logic [K_W-1:0] k;
    logic [W_W-1:0] w1;
    logic [W_W-1:0] w2;
    logic [W_W-1:0] w3;
  } cbe_wgt_t;

endpackage

// ----- rtl/cbe_cfg_regs.sv -----
`timescale 1ns / 1ps

module cbe_cfg_regs import cbe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cbe_ctrl_t         ctrl
);

  cbe_ctrl_t ctrl_r;
  cbe_reg_t  reg_sel;
  logic      wr_en;

  assign reg_sel = cbe_reg_t'(paddr[APB_AW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign ctrl    = ctrl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.c1_x <= '0;
      ctrl_r.c1_y <= '0;
      ctrl_r.c2_x <= COORD_W'(1 << FRAC_COORD);
      ctrl_r.c2_y <= COORD_W'(1 << FRAC_COORD);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_C1X: ctrl_r.c1_x <= pwdata[COORD_W-1:0];
        REG_C1Y: ctrl_r.c1_y <= pwdata[COORD_W-1:0];
        REG_C2X: ctrl_r.c2_x <= pwdata[COORD_W-1:0];
        REG_C2Y: ctrl_r.c2_y <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_C1X: prdata = APB_DW'(ctrl_r.c1_x);
      REG_C1Y: prdata = APB_DW'(ctrl_r.c1_y);
      REG_C2X: prdata = APB_DW'(ctrl_r.c2_x);
      REG_C2Y: prdata = APB_DW'(ctrl_r.c2_y);
      default: prdata = '0;
    endcase
  end

endmodule

// ----- rtl/cbe_weights.sv -----
`timescale 1ns / 1ps

module cbe_weights import cbe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [POS_W-1:0] in_position,
  output cbe_wgt_t                wgt,
  input  logic                    wgt_ready
);

  localparam logic signed [POS_W-1:0] ONE_POS = POS_W'(1 << FRAC_POS);
  localparam int E_W = 3 * K_W + 2;

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  logic [FRAC_POS:0]  pos_cl;
  logic [K_W-1:0]     k_nxt;
  logic [K_W-1:0]     k1_r;

  logic [K_W-1:0]     u1;
  logic [2*K_W-1:0]   uu_nxt, kk_nxt;
  logic [2*K_W-1:0]   uu2_r, kk2_r;
  logic [K_W-1:0]     k2_r, u2_r;

  logic [E_W-1:0]     t1, t2, w1_full, w2_full, w3_full;
  logic [K_W-1:0]     k3_r;
  logic [W_W-1:0]     w1_3_r, w2_3_r, w3_3_r;

  // each stage moves when it is empty or the next one moves
  assign adv3     = !v3_r || wgt_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  // clamp to [0,1] and quantize down to a sample index
  always_comb begin
    if (in_position[POS_W-1]) begin
      pos_cl = '0;
    end else if (in_position > ONE_POS) begin
      pos_cl = ONE_POS[FRAC_POS:0];
    end else begin
      pos_cl = in_position[FRAC_POS:0];
    end
  end
  assign k_nxt = pos_cl[FRAC_POS -: K_W];

  assign u1     = K_W'(STEPS) - k1_r;
  assign uu_nxt = (2*K_W)'(u1) * (2*K_W)'(u1);
  assign kk_nxt = (2*K_W)'(k1_r) * (2*K_W)'(k1_r);

  // w1 = 3 u^2 k, w2 = 3 u k^2, w3 = k^3
  assign t1      = E_W'(uu2_r) * E_W'(k2_r);
  assign t2      = E_W'(kk2_r) * E_W'(u2_r);
  assign w1_full = t1 + (t1 << 1);
  assign w2_full = t2 + (t2 << 1);
  assign w3_full = E_W'(kk2_r) * E_W'(k2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      k1_r <= k_nxt;
    end
    if (adv2 && v1_r) begin
      uu2_r <= uu_nxt;
      kk2_r <= kk_nxt;
      k2_r  <= k1_r;
      u2_r  <= u1;
    end
    if (adv3 && v2_r) begin
      k3_r   <= k2_r;
      w1_3_r <= w1_full[W_W-1:0];
      w2_3_r <= w2_full[W_W-1:0];
      w3_3_r <= w3_full[W_W-1:0];
    end
  end

  assign wgt.valid = v3_r;
  assign wgt.k     = k3_r;
  assign wgt.w1    = w1_3_r;
  assign wgt.w2    = w2_3_r;
  assign wgt.w3    = w3_3_r;

endmodule

// ----- rtl/cbe_blend.sv -----
`timescale 1ns / 1ps

module cbe_blend import cbe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cbe_wgt_t                  wgt,
  output logic                      wgt_ready,
  input  cbe_ctrl_t                 ctrl,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [IDX_W-1:0]          out_sample_index,
  output logic signed [COORD_W-1:0] out_curve_x,
  output logic signed [COORD_W-1:0] out_curve_y
);

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (RND_SHIFT - 1);

  logic v4_r, out_valid_r;
  logic adv4, adv5;

  logic signed [W_W:0]     w1_s, w2_s;
  logic signed [P_W-1:0]   p1x_nxt, p2x_nxt, p1y_nxt, p2y_nxt;
  logic signed [P_W-1:0]   p1x_r, p2x_r, p1y_r, p2y_r;
  logic [W_W-1:0]          w3_4_r;
  logic [K_W-1:0]          k4_r;

  logic signed [SUM_W-1:0] end_term, sum_x, sum_y, rx, ry;
  logic [IDX_W-1:0]          idx_r;
  logic signed [COORD_W-1:0] cx_r, cy_r;

  assign adv5      = !out_valid_r || !out_stall;
  assign adv4      = !v4_r || adv5;
  assign wgt_ready = adv4;

  assign w1_s    = $signed({1'b0, wgt.w1});
  assign w2_s    = $signed({1'b0, wgt.w2});
  assign p1x_nxt = w1_s * ctrl.c1_x;
  assign p2x_nxt = w2_s * ctrl.c2_x;
  assign p1y_nxt = w1_s * ctrl.c1_y;
  assign p2y_nxt = w2_s * ctrl.c2_y;

  // end point (1,1) term is k^3 times one, the start point adds nothing
  assign end_term = $signed(SUM_W'({w3_4_r, {FRAC_COORD{1'b0}}}));
  assign sum_x    = SUM_W'(p1x_r) + SUM_W'(p2x_r) + end_term + HALF;
  assign sum_y    = SUM_W'(p1y_r) + SUM_W'(p2y_r) + end_term + HALF;
  // arithmetic shift floors, so halves go toward plus infinity
  assign rx       = sum_x >>> RND_SHIFT;
  assign ry       = sum_y >>> RND_SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv4) v4_r        <= wgt.valid;
      if (adv5) out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && wgt.valid) begin
      p1x_r  <= p1x_nxt;
      p2x_r  <= p2x_nxt;
      p1y_r  <= p1y_nxt;
      p2y_r  <= p2y_nxt;
      w3_4_r <= wgt.w3;
      k4_r   <= wgt.k;
    end
    if (adv5 && v4_r) begin
      idx_r <= IDX_W'(k4_r);
      cx_r  <= rx[COORD_W-1:0];
      cy_r  <= ry[COORD_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_index = idx_r;
  assign out_curve_x      = cx_r;
  assign out_curve_y      = cy_r;

endmodule

// ----- rtl/cubic_bezier_easing_eval_core.sv -----
`timescale 1ns / 1ps

// Cubic Bezier easing evaluator with end points (0,0) and (1,1) and two inner
// control points set over the APB port (Q2.14, byte addresses 0, 4, 8, 12).
// Each position (Q2.16) is clamped to [0,1], quantized down to a sample
// k = floor(position * STEPS), and the curve point at t = k / STEPS is returned
// with k, rounded to nearest Q2.14. The datapath is a five-stage pipeline
// (clamp and quantize, u^2 / k^2 products, Bernstein weights, control
// multiplies, sum and round) that takes one transaction per clock when not
// stalled; the result passes each stage register in turn. A stall at the
// output holds only the stages behind a full stage, so empty stages keep
// filling and the input keeps accepting until the pipeline is full. Control
// registers are read by the fourth stage and should only be written while idle.

module cubic_bezier_easing_eval_core import cbe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [POS_W-1:0]   in_position,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [IDX_W-1:0]          out_sample_index,
  output logic signed [COORD_W-1:0] out_curve_x,
  output logic signed [COORD_W-1:0] out_curve_y
);

  cbe_ctrl_t ctrl;
  cbe_wgt_t  wgt;
  logic      wgt_ready;

  cbe_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctrl    (ctrl)
  );

  cbe_weights u_wgt (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_position (in_position),
    .wgt         (wgt),
    .wgt_ready   (wgt_ready)
  );

  cbe_blend u_blend (
    .clk              (clk),
    .rst_n            (rst_n),
    .wgt              (wgt),
    .wgt_ready        (wgt_ready),
    .ctrl             (ctrl),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_index (out_sample_index),
    .out_curve_x      (out_curve_x),
    .out_curve_y      (out_curve_y)
  );

  // an empty output register lets the whole pipeline move
  a_empty_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with output register empty");

  a_start_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_index == '0 |-> out_curve_x == '0 && out_curve_y == '0)
    else $error("sample zero is not the origin");

  a_end_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_index == IDX_W'(STEPS) |->
      out_curve_x == COORD_W'(1 << FRAC_COORD) && out_curve_y == COORD_W'(1 << FRAC_COORD))
    else $error("last sample is not the end point");

  a_stall_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

endmodule
